// ===== rtl/svpc_pkg.sv =====
// shared types and constants for the space vector pwm compare generator
package svpc_pkg;

    // unsigned q30 word, enough headroom for pi/3 and its square
    localparam int Q30_W = 31;
    typedef logic [Q30_W-1:0] q30_t;
    localparam q30_t Q30_ONE = 31'h4000_0000;

    // pi/3 in q30 and 4/pi in q16
    localparam logic [30:0] PI3_Q30 = 31'd1124419809;
    localparam logic [16:0] FOUR_OVER_PI_Q16 = 17'd83443;

    // taylor series, innermost divisor first
    localparam int CELL_LAT = 3;
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;
    localparam int SIN_DIV [SIN_TERMS] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [COS_TERMS] = '{132, 90, 56, 30, 12, 2};

    // signed q43 time sums
    localparam int SUM_W = 51;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam logic [15:0] GAIN_RESET = 16'd16384;

    typedef enum logic [0:0] {
        REG_AUTO_RELOAD = 1'b0,
        REG_GAIN        = 1'b1
    } cfg_reg_t;

endpackage

// ===== rtl/svpc_taylor_cell.sv =====
// one nested taylor step: t_out = 1 - (x2 * t_in) / DIV, three register stages
module svpc_taylor_cell
    import svpc_pkg::*;
#(
    parameter int DIV = 6
)
(
    input  logic clk,
    input  q30_t x2_in,
    input  q30_t t_in,
    output q30_t x2_out,
    output q30_t t_out
);

    localparam logic [32:0] RECIP_FULL = (33'd1 << 32) / DIV;
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];

    logic [61:0] prod;
    logic [62:0] recip_prod;
    q30_t        q0_next;
    q30_t        rem;
    q30_t        quo;
    q30_t        t_next;

    q30_t v1_reg;
    q30_t x2_1_reg;
    q30_t v2_reg;
    q30_t q0_reg;
    q30_t x2_2_reg;
    q30_t t3_reg;
    q30_t x2_3_reg;

    assign prod = 62'(x2_in) * 62'(t_in);

    // reciprocal estimate is low by at most one
    assign recip_prod = 63'(v1_reg) * 63'(RECIP);
    assign q0_next    = recip_prod[62:32];

    always_comb
    begin
        rem    = v2_reg - 31'(q0_reg * 31'(DIV));
        quo    = q0_reg + 31'(rem >= 31'(DIV));
        t_next = Q30_ONE - quo;
    end

    always_ff @(posedge clk)
    begin
        v1_reg   <= prod[60:30];
        x2_1_reg <= x2_in;
        v2_reg   <= v1_reg;
        q0_reg   <= q0_next;
        x2_2_reg <= x2_1_reg;
        t3_reg   <= t_next;
        x2_3_reg <= x2_2_reg;
    end

    assign x2_out = x2_3_reg;
    assign t_out  = t3_reg;

endmodule

// ===== rtl/svpc_scale.sv =====
// scales a q43 time sum to timer counts, rounds half up and clamps, two stages
module svpc_scale
    import svpc_pkg::*;
#(
    parameter int ARR_BITS = 16
)
(
    input  logic                clk,
    input  logic [ARR_BITS-1:0] arr,
    input  sum_t                t_in,
    output logic [15:0]         cmp
);

    localparam int PH_W = ARR_BITS + 22;
    localparam int PL_W = ARR_BITS + 21;
    localparam int S_W  = ARR_BITS + 44;

    logic            neg_next;
    logic            big_next;
    logic [PH_W-1:0] ph_next;
    logic [PL_W-1:0] pl_next;
    logic [S_W-1:0]  sum;
    logic [ARR_BITS:0] rnd;
    logic [ARR_BITS-1:0] cmp_next;

    logic            neg_reg;
    logic            big_reg;
    logic [PH_W-1:0] ph_reg;
    logic [PL_W-1:0] pl_reg;
    logic [15:0]     cmp_reg;

    assign neg_next = t_in[SUM_W-1] || (t_in == '0);
    assign big_next = !t_in[SUM_W-1] && (|t_in[SUM_W-2:43]);
    assign ph_next  = PH_W'(arr) * PH_W'(t_in[42:21]);
    assign pl_next  = PL_W'(arr) * PL_W'(t_in[20:0]);

    always_comb
    begin
        sum = (S_W'(ph_reg) << 21) + S_W'(pl_reg) + (S_W'(1) << 42);
        rnd = sum[S_W-1:43];
        priority if (neg_reg)
            cmp_next = '0;
        else if (big_reg || (rnd > (ARR_BITS+1)'(arr)))
            cmp_next = arr;
        else
            cmp_next = rnd[ARR_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        big_reg <= big_next;
        ph_reg  <= ph_next;
        pl_reg  <= pl_next;
        cmp_reg <= 16'(cmp_next);
    end

    assign cmp = cmp_reg;

endmodule

// ===== rtl/space_vector_pwm_compare.sv =====
// top level: space vector pwm compare generator with taylor cell chains
//
// usage: pulse start with modulation (unsigned q2.14) and phase (a full turn is
// 2^PHASE_BITS). busy stays low, so an item can be started on every clock.
// the three compare values come out on compare_a/b/c for one cycle, marked by
// done; items leave in the order they came. the pipeline has no hold, so the
// receiver must take each result in the cycle it is shown. the latency is set
// by the cosine series: six taylor cells of three stages each, plus angle
// set-up, sine/cos3t, time products, a three stage divide by three, the sector
// sums and the two stage scaling to timer counts.
// config: cfg_index 0 is auto_reload, 1 is gain; cfg_ready is always high.
// write the registers only while no item is in flight.
// reset clears the valid pipeline and sets auto_reload to all ones (ARR_BITS wide,
// that is COMPARE_BITS capped at 16) and gain to 1.0.
module space_vector_pwm_compare
    import svpc_pkg::*;
#(
    parameter int PHASE_BITS   = 16,
    parameter int COMPARE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [15:0]           modulation,
    input  logic [PHASE_BITS-1:0] phase,
    output logic                  done,
    output logic [15:0]           compare_a,
    output logic [15:0]           compare_b,
    output logic [15:0]           compare_c,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int ARR_BITS   = (COMPARE_BITS < 16) ? COMPARE_BITS : 16;
    localparam int CHAIN_LAT  = COS_TERMS * CELL_LAT;
    localparam int SIN_PAD    = (COS_TERMS - SIN_TERMS) * CELL_LAT;
    localparam int DIV_STAGES = 3;
    localparam int LATENCY    = 3 + CHAIN_LAT + 4 + DIV_STAGES + 2 + 2;

    // configuration
    logic [ARR_BITS-1:0] arr_reg;
    logic [15:0]         gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arr_reg  <= '1;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AUTO_RELOAD: arr_reg  <= cfg_data[ARR_BITS-1:0];
                REG_GAIN:        gain_reg <= cfg_data;
                default:         arr_reg  <= arr_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // stage 1: sector and mirrored angle inside it
    logic [PHASE_BITS+2:0] p6;
    logic [2:0]            sec_next;
    logic [PHASE_BITS:0]   rem_m;
    logic [16:0]           f_next;
    logic [16:0]           fa_next;

    assign p6       = {1'b0, phase, 2'b00} + {2'b00, phase, 1'b0};
    assign sec_next = p6[PHASE_BITS+2:PHASE_BITS];
    assign rem_m    = sec_next[0] ? ({1'b1, {PHASE_BITS{1'b0}}} - {1'b0, p6[PHASE_BITS-1:0]})
                                  : {1'b0, p6[PHASE_BITS-1:0]};

    generate
        if (PHASE_BITS >= 16)
        begin : g_f_trunc
            assign f_next = 17'(rem_m >> (PHASE_BITS - 16));
        end
        else
        begin : g_f_widen
            assign f_next = 17'(rem_m) << (16 - PHASE_BITS);
        end
    endgenerate

    assign fa_next = 17'd65536 - f_next;

    logic        s1_v_reg;
    logic [2:0]  s1_sec_reg;
    logic [15:0] s1_m_reg;
    logic [16:0] s1_f_reg;
    logic [16:0] s1_fa_reg;

    // stage 2: angles to radians in q30
    logic [47:0] xa_prod;
    logic [47:0] xb_prod;

    assign xa_prod = 48'(s1_fa_reg) * 48'(PI3_Q30) + 48'd32768;
    assign xb_prod = 48'(s1_f_reg) * 48'(PI3_Q30) + 48'd32768;

    logic        s2_v_reg;
    logic [2:0]  s2_sec_reg;
    logic [15:0] s2_m_reg;
    q30_t        s2_xa_reg;
    q30_t        s2_xb_reg;

    // stage 3: squares for the series
    logic [61:0] x2a_prod;
    logic [61:0] x2b_prod;

    assign x2a_prod = 62'(s2_xa_reg) * 62'(s2_xa_reg);
    assign x2b_prod = 62'(s2_xb_reg) * 62'(s2_xb_reg);

    logic        s3_v_reg;
    logic [2:0]  s3_sec_reg;
    logic [15:0] s3_m_reg;
    q30_t        s3_xa_reg;
    q30_t        s3_xb_reg;
    q30_t        s3_x2a_reg;
    q30_t        s3_x2b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sec_reg <= sec_next;
        s1_m_reg   <= modulation;
        s1_f_reg   <= f_next;
        s1_fa_reg  <= fa_next;
        s2_sec_reg <= s1_sec_reg;
        s2_m_reg   <= s1_m_reg;
        s2_xa_reg  <= xa_prod[46:16];
        s2_xb_reg  <= xb_prod[46:16];
        s3_sec_reg <= s2_sec_reg;
        s3_m_reg   <= s2_m_reg;
        s3_xa_reg  <= s2_xa_reg;
        s3_xb_reg  <= s2_xb_reg;
        s3_x2a_reg <= x2a_prod[60:30];
        s3_x2b_reg <= x2b_prod[60:30];
    end

    // taylor cell chains: sin(60 - t), sin(t), cos(t)
    q30_t sa_x2 [0:SIN_TERMS-1];
    q30_t sa_t  [0:SIN_TERMS];
    q30_t sb_x2 [0:SIN_TERMS-1];
    q30_t sb_t  [0:SIN_TERMS];
    q30_t cs_x2 [0:COS_TERMS-1];
    q30_t cs_t  [0:COS_TERMS];

    assign sa_x2[0] = s3_x2a_reg;
    assign sa_t[0]  = Q30_ONE;
    assign sb_x2[0] = s3_x2b_reg;
    assign sb_t[0]  = Q30_ONE;
    assign cs_x2[0] = s3_x2b_reg;
    assign cs_t[0]  = Q30_ONE;

    genvar gi;
    generate
        for (gi = 0; gi < SIN_TERMS; gi++)
        begin : g_sin
            if (gi < SIN_TERMS - 1)
            begin : g_mid
                svpc_taylor_cell #(.DIV(SIN_DIV[gi])) u_cell_a
                (
                    .clk    (clk),
                    .x2_in  (sa_x2[gi]),
                    .t_in   (sa_t[gi]),
                    .x2_out (sa_x2[gi+1]),
                    .t_out  (sa_t[gi+1])
                );
                svpc_taylor_cell #(.DIV(SIN_DIV[gi])) u_cell_b
                (
                    .clk    (clk),
                    .x2_in  (sb_x2[gi]),
                    .t_in   (sb_t[gi]),
                    .x2_out (sb_x2[gi+1]),
                    .t_out  (sb_t[gi+1])
                );
            end
            else
            begin : g_last
                svpc_taylor_cell #(.DIV(SIN_DIV[gi])) u_cell_a
                (
                    .clk    (clk),
                    .x2_in  (sa_x2[gi]),
                    .t_in   (sa_t[gi]),
                    .x2_out (),
                    .t_out  (sa_t[gi+1])
                );
                svpc_taylor_cell #(.DIV(SIN_DIV[gi])) u_cell_b
                (
                    .clk    (clk),
                    .x2_in  (sb_x2[gi]),
                    .t_in   (sb_t[gi]),
                    .x2_out (),
                    .t_out  (sb_t[gi+1])
                );
            end
        end

        for (gi = 0; gi < COS_TERMS; gi++)
        begin : g_cos
            if (gi < COS_TERMS - 1)
            begin : g_mid
                svpc_taylor_cell #(.DIV(COS_DIV[gi])) u_cell
                (
                    .clk    (clk),
                    .x2_in  (cs_x2[gi]),
                    .t_in   (cs_t[gi]),
                    .x2_out (cs_x2[gi+1]),
                    .t_out  (cs_t[gi+1])
                );
            end
            else
            begin : g_last
                svpc_taylor_cell #(.DIV(COS_DIV[gi])) u_cell
                (
                    .clk    (clk),
                    .x2_in  (cs_x2[gi]),
                    .t_in   (cs_t[gi]),
                    .x2_out (),
                    .t_out  (cs_t[gi+1])
                );
            end
        end
    endgenerate

    // sine results wait for the longer cosine chain
    q30_t ta_dly_reg [0:SIN_PAD-1];
    q30_t tb_dly_reg [0:SIN_PAD-1];

    // item fields riding alongside the chains
    logic        sbv_reg   [0:CHAIN_LAT-1];
    logic [2:0]  sbsec_reg [0:CHAIN_LAT-1];
    logic [15:0] sbm_reg   [0:CHAIN_LAT-1];
    q30_t        sbxa_reg  [0:CHAIN_LAT-1];
    q30_t        sbxb_reg  [0:CHAIN_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAIN_LAT; i++)
                sbv_reg[i] <= 1'b0;
        end
        else
        begin
            sbv_reg[0] <= s3_v_reg;
            for (int i = 1; i < CHAIN_LAT; i++)
                sbv_reg[i] <= sbv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ta_dly_reg[0] <= sa_t[SIN_TERMS];
        tb_dly_reg[0] <= sb_t[SIN_TERMS];
        for (int i = 1; i < SIN_PAD; i++)
        begin
            ta_dly_reg[i] <= ta_dly_reg[i-1];
            tb_dly_reg[i] <= tb_dly_reg[i-1];
        end
        sbsec_reg[0] <= s3_sec_reg;
        sbm_reg[0]   <= s3_m_reg;
        sbxa_reg[0]  <= s3_xa_reg;
        sbxb_reg[0]  <= s3_xb_reg;
        for (int i = 1; i < CHAIN_LAT; i++)
        begin
            sbsec_reg[i] <= sbsec_reg[i-1];
            sbm_reg[i]   <= sbm_reg[i-1];
            sbxa_reg[i]  <= sbxa_reg[i-1];
            sbxb_reg[i]  <= sbxb_reg[i-1];
        end
    end

    // e1: final sine products, cos squared
    logic [61:0] sa_prod;
    logic [61:0] sb_prod;
    logic [61:0] cc_prod;

    assign sa_prod = 62'(sbxa_reg[CHAIN_LAT-1]) * 62'(ta_dly_reg[SIN_PAD-1]);
    assign sb_prod = 62'(sbxb_reg[CHAIN_LAT-1]) * 62'(tb_dly_reg[SIN_PAD-1]);
    assign cc_prod = 62'(cs_t[COS_TERMS]) * 62'(cs_t[COS_TERMS]);

    logic        e1_v_reg;
    logic [2:0]  e1_sec_reg;
    logic [15:0] e1_m_reg;
    q30_t        e1_sa_reg;
    q30_t        e1_sb_reg;
    q30_t        e1_cc_reg;
    q30_t        e1_c30_reg;

    // e2: round sines to q15, cos cubed, gain and 4/pi products
    logic [31:0] sa_rnd;
    logic [31:0] sb_rnd;
    logic [31:0] c1_rnd;
    logic [61:0] ccc_prod;

    assign sa_rnd   = 32'(e1_sa_reg) + 32'd16384;
    assign sb_rnd   = 32'(e1_sb_reg) + 32'd16384;
    assign c1_rnd   = 32'(e1_c30_reg) + 32'd16384;
    assign ccc_prod = 62'(e1_cc_reg) * 62'(e1_c30_reg);

    logic        e2_v_reg;
    logic [2:0]  e2_sec_reg;
    logic [16:0] e2_sa_reg;
    logic [16:0] e2_sb_reg;
    logic [16:0] e2_c1_reg;
    q30_t        e2_ccc_reg;
    q30_t        e2_c30_reg;
    logic [31:0] e2_gm_reg;
    logic [32:0] e2_km_reg;

    // e3: cos(3t), harmonic sum, active times
    logic signed [35:0] c3v;
    logic signed [35:0] c3s;
    logic [20:0]        c3u;
    logic [21:0]        h6w;

    always_comb
    begin
        c3v = $signed({3'b000, e2_ccc_reg, 2'b00}) - $signed(36'(e2_c30_reg) * 36'd3);
        c3s = c3v + 36'sd2147500032;
        c3u = c3s[35:15];
        h6w = 22'(e2_c1_reg) * 22'd6 + 22'd65536 - 22'(c3u);
    end

    logic        e3_v_reg;
    logic [2:0]  e3_sec_reg;
    logic [47:0] e3_ta_reg;
    logic [47:0] e3_tb_reg;
    logic [18:0] e3_h6_reg;
    logic [32:0] e3_km_reg;

    // e4 feeds the divide by 48 (shift by four, then three chunks of divide by three)
    logic [51:0] qn;

    assign qn = 52'(e3_km_reg) * 52'(e3_h6_reg) + 52'd24;

    logic        dv_reg   [0:DIV_STAGES];
    logic [2:0]  dsec_reg [0:DIV_STAGES];
    logic [47:0] dta_reg  [0:DIV_STAGES];
    logic [47:0] dtb_reg  [0:DIV_STAGES];
    logic [47:0] dval_reg [0:DIV_STAGES];
    logic [47:0] dq_reg   [0:DIV_STAGES];
    logic [1:0]  dr_reg   [0:DIV_STAGES];
    logic [17:0] dres     [0:DIV_STAGES-1];

    function automatic logic [17:0] div3_chunk(input logic [1:0] r_in, input logic [15:0] c);
        logic [17:0] w;
        logic [33:0] p;
        logic [15:0] q0;
        logic [17:0] r;
        w  = {r_in, c};
        p  = 34'(w) * 34'd21845;
        q0 = p[31:16];
        r  = w - 18'(q0) * 18'd3;
        if (r >= 18'd3)
        begin
            q0 = q0 + 16'd1;
            r  = r - 18'd3;
        end
        return {r[1:0], q0};
    endfunction

    always_comb
    begin
        for (int i = 0; i < DIV_STAGES; i++)
            dres[i] = div3_chunk(dr_reg[i], dval_reg[i][47-16*i -: 16]);
    end

    // e8: zero time and combined active time
    sum_t        t0_next;
    logic [48:0] tab_next;

    assign t0_next  = (sum_t'(1) <<< 42) - sum_t'({3'b000, dq_reg[DIV_STAGES]});
    assign tab_next = 49'(dta_reg[DIV_STAGES]) + 49'(dtb_reg[DIV_STAGES]);

    logic        e8_v_reg;
    logic [2:0]  e8_sec_reg;
    sum_t        e8_t0_reg;
    logic [47:0] e8_ta_reg;
    logic [48:0] e8_tab_reg;

    // e9: sector sums routed to the channels
    sum_t z;
    sum_t za;
    sum_t zab;
    sum_t r1_next;
    sum_t r2_next;
    sum_t r3_next;

    always_comb
    begin
        z   = e8_t0_reg;
        za  = e8_t0_reg + sum_t'({3'b000, e8_ta_reg});
        zab = e8_t0_reg + sum_t'({2'b00, e8_tab_reg});
        unique case (e8_sec_reg)
            3'd0:
            begin
                r1_next = z;   r2_next = za;  r3_next = zab;
            end
            3'd1:
            begin
                r1_next = za;  r2_next = z;   r3_next = zab;
            end
            3'd2:
            begin
                r1_next = zab; r2_next = z;   r3_next = za;
            end
            3'd3:
            begin
                r1_next = zab; r2_next = za;  r3_next = z;
            end
            3'd4:
            begin
                r1_next = za;  r2_next = zab; r3_next = z;
            end
            default:
            begin
                r1_next = z;   r2_next = zab; r3_next = za;
            end
        endcase
    end

    logic e9_v_reg;
    sum_t e9_r1_reg;
    sum_t e9_r2_reg;
    sum_t e9_r3_reg;
    logic sca_v_reg;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg  <= 1'b0;
            e2_v_reg  <= 1'b0;
            e3_v_reg  <= 1'b0;
            for (int i = 0; i <= DIV_STAGES; i++)
                dv_reg[i] <= 1'b0;
            e8_v_reg  <= 1'b0;
            e9_v_reg  <= 1'b0;
            sca_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            e1_v_reg  <= sbv_reg[CHAIN_LAT-1];
            e2_v_reg  <= e1_v_reg;
            e3_v_reg  <= e2_v_reg;
            dv_reg[0] <= e3_v_reg;
            for (int i = 0; i < DIV_STAGES; i++)
                dv_reg[i+1] <= dv_reg[i];
            e8_v_reg  <= dv_reg[DIV_STAGES];
            e9_v_reg  <= e8_v_reg;
            sca_v_reg <= e9_v_reg;
            done_reg  <= sca_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_sec_reg <= sbsec_reg[CHAIN_LAT-1];
        e1_m_reg   <= sbm_reg[CHAIN_LAT-1];
        e1_sa_reg  <= sa_prod[60:30];
        e1_sb_reg  <= sb_prod[60:30];
        e1_cc_reg  <= cc_prod[60:30];
        e1_c30_reg <= cs_t[COS_TERMS];

        e2_sec_reg <= e1_sec_reg;
        e2_sa_reg  <= sa_rnd[31:15];
        e2_sb_reg  <= sb_rnd[31:15];
        e2_c1_reg  <= c1_rnd[31:15];
        e2_ccc_reg <= ccc_prod[60:30];
        e2_c30_reg <= e1_c30_reg;
        e2_gm_reg  <= 32'(gain_reg) * 32'(e1_m_reg);
        e2_km_reg  <= 33'(FOUR_OVER_PI_Q16) * 33'(e1_m_reg);

        e3_sec_reg <= e2_sec_reg;
        e3_ta_reg  <= 48'(e2_gm_reg) * 48'(e2_sa_reg);
        e3_tb_reg  <= 48'(e2_gm_reg) * 48'(e2_sb_reg);
        e3_h6_reg  <= h6w[18:0];
        e3_km_reg  <= e2_km_reg;

        dsec_reg[0] <= e3_sec_reg;
        dta_reg[0]  <= e3_ta_reg;
        dtb_reg[0]  <= e3_tb_reg;
        dval_reg[0] <= qn[51:4];
        dq_reg[0]   <= '0;
        dr_reg[0]   <= '0;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            dsec_reg[i+1] <= dsec_reg[i];
            dta_reg[i+1]  <= dta_reg[i];
            dtb_reg[i+1]  <= dtb_reg[i];
            dval_reg[i+1] <= dval_reg[i];
            dq_reg[i+1]   <= {dq_reg[i][31:0], dres[i][15:0]};
            dr_reg[i+1]   <= dres[i][17:16];
        end

        e8_sec_reg <= dsec_reg[DIV_STAGES];
        e8_t0_reg  <= t0_next;
        e8_ta_reg  <= dta_reg[DIV_STAGES];
        e8_tab_reg <= tab_next;

        e9_r1_reg <= r1_next;
        e9_r2_reg <= r2_next;
        e9_r3_reg <= r3_next;
    end

    svpc_scale #(.ARR_BITS(ARR_BITS)) u_scale_a
    (
        .clk  (clk),
        .arr  (arr_reg),
        .t_in (e9_r1_reg),
        .cmp  (compare_a)
    );

    svpc_scale #(.ARR_BITS(ARR_BITS)) u_scale_b
    (
        .clk  (clk),
        .arr  (arr_reg),
        .t_in (e9_r2_reg),
        .cmp  (compare_b)
    );

    svpc_scale #(.ARR_BITS(ARR_BITS)) u_scale_c
    (
        .clk  (clk),
        .arr  (arr_reg),
        .t_in (e9_r3_reg),
        .cmp  (compare_c)
    );

    assign done = done_reg;

    // every started item comes out on done, none is lost in the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("item lost in pipeline");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result without a started item");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (compare_a <= 16'(arr_reg)) && (compare_b <= 16'(arr_reg))
                 && (compare_c <= 16'(arr_reg)))
        else $error("compare above reload");

    a_sector: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> s1_sec_reg <= 3'd5)
        else $error("sector out of range");

endmodule
